// File: src/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int SKT_CAPACITY = 64;

   localparam int KEY_W    = 31;
   localparam int HANDLE_W = 32;
   localparam int SIZE_W   = 16;
   localparam int COUNT_W  = 7;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_SET    = 2'd1,
      OP_DELETE = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INSERTED  = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CL_LOOKUP,
      CL_SET,
      CL_DELETE,
      CL_NONE
   } class_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SEARCH,
      BK_CMP,
      BK_SHIFT_RD,
      BK_SHIFT_WR,
      BK_PLACE,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      class_type             cls;
      logic [KEY_W-1:0]      key;
      logic [HANDLE_W-1:0]   handle;
      logic [SIZE_W-1:0]     size;
   } item_type;

   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic [HANDLE_W-1:0]   handle;
      logic [SIZE_W-1:0]     size;
   } entry_type;

endpackage

// File: src/skt_if.sv
// ----------------------------------------------------------------------------
// skt_req_if / skt_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface skt_req_if;
   import skt_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   logic [KEY_W-1:0]    key;
   logic [HANDLE_W-1:0] value_handle;
   logic [SIZE_W-1:0]   value_size;

   modport source (output valid, opcode, key, value_handle, value_size, input ready);
   modport sink   (input valid, opcode, key, value_handle, value_size, output ready);
endinterface

interface skt_rsp_if;
   import skt_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [HANDLE_W-1:0] handle_out;
   logic [SIZE_W-1:0]   size_out;
   logic [COUNT_W-1:0]  entry_count;

   modport source  (output valid, status, handle_out, size_out, entry_count, input ready);
   modport sink    (input valid, status, handle_out, size_out, entry_count, output ready);
   modport monitor (input valid, ready, status, handle_out, size_out, entry_count);
endinterface

// File: src/skt_front.sv
// ----------------------------------------------------------------------------
// skt_front
// Accepts requests, classifies the opcode and queues them for the engine.
// ----------------------------------------------------------------------------
module skt_front (
   input  logic              clock,
   input  logic              reset,
   skt_req_if.sink           req_chan,
   output logic              item_valid,
   input  logic              item_ready,
   output skt_pkg::item_type item
);
   import skt_pkg::*;

   item_type   q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   new_item;
   logic       push, pop;

   always_comb begin
      new_item.key    = req_chan.key;
      new_item.handle = req_chan.value_handle;
      new_item.size   = req_chan.value_size;
      case (req_chan.opcode)
         OP_LOOKUP: new_item.cls = CL_LOOKUP;
         OP_SET:    new_item.cls = CL_SET;
         OP_DELETE: new_item.cls = CL_DELETE;
         default:   new_item.cls = CL_NONE;
      endcase
   end

   assign req_chan.ready = (cnt_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign item_valid     = (cnt_ff != 2'd0);
   assign pop            = item_valid && item_ready;
   assign item           = q_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop  ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= new_item;
      end
   end

endmodule

// File: src/skt_back.sv
// ----------------------------------------------------------------------------
// skt_back
// Binary search, shift and write-back engine over the entry memory.
// ----------------------------------------------------------------------------
module skt_back #(
   parameter int CAPACITY = skt_pkg::SKT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  skt_pkg::item_type item,
   skt_rsp_if.source         rsp_chan
);
   import skt_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   entry_type      mem [CAPACITY];
   entry_type      rd_data_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   entry_type      mem_wdata;

   back_state_type state_ff, state_in;
   item_type       item_ff, item_in;
   logic [CW-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CW-1:0]  cur_ff, cur_in, pos_ff, pos_in, used_ff, used_in;
   status_type     status_ff, status_in;
   logic [HANDLE_W-1:0] hout_ff, hout_in;
   logic [SIZE_W-1:0]   sout_ff, sout_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [CW-1:0]  mid;
   logic           up;
   entry_type      new_entry;

   assign item_ready = (state_ff == BK_IDLE);
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign up         = (status_ff == ST_INSERTED);
   assign new_entry  = '{key: item_ff.key, handle: item_ff.handle, size: item_ff.size};

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.handle_out  = rsp_handle_ff;
   assign rsp_chan.size_out    = rsp_size_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      used_in       = used_ff;
      status_in     = status_ff;
      hout_in       = hout_ff;
      sout_in       = sout_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = rd_data_ff;
      mem_raddr     = '0;

      case (state_ff)
         BK_IDLE: begin
            if (item_valid) begin
               item_in   = item;
               lo_in     = '0;
               hi_in     = used_ff;
               hout_in   = '0;
               sout_in   = '0;
               status_in = ST_NOT_FOUND;
               state_in  = (item.cls == CL_NONE) ? BK_DONE : BK_SEARCH;
            end
         end
         BK_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mem_raddr = mid[AW-1:0];
               mid_in    = mid;
               state_in  = BK_CMP;
            end else begin
               pos_in = lo_ff;
               if (item_ff.cls == CL_SET) begin
                  if (used_ff >= CAP_C) begin
                     status_in = ST_FULL;
                     state_in  = BK_DONE;
                  end else begin
                     status_in = ST_INSERTED;
                     cur_in    = used_ff;
                     state_in  = BK_SHIFT_RD;
                  end
               end else begin
                  state_in = BK_DONE;
               end
            end
         end
         BK_CMP: begin
            if (rd_data_ff.key == item_ff.key) begin
               pos_in    = mid_ff;
               status_in = ST_OK;
               hout_in   = rd_data_ff.handle;
               sout_in   = rd_data_ff.size;
               case (item_ff.cls)
                  CL_SET: begin
                     mem_we    = 1'b1;
                     mem_waddr = mid_ff[AW-1:0];
                     mem_wdata = new_entry;
                     state_in  = BK_DONE;
                  end
                  CL_DELETE: begin
                     cur_in   = mid_ff;
                     state_in = BK_SHIFT_RD;
                  end
                  default: state_in = BK_DONE;
               endcase
            end else if (rd_data_ff.key > item_ff.key) begin
               hi_in    = mid_ff;
               state_in = BK_SEARCH;
            end else begin
               lo_in    = mid_ff + 1'b1;
               state_in = BK_SEARCH;
            end
         end
         BK_SHIFT_RD: begin
            if (up) begin
               if (cur_ff > pos_ff) begin
                  mem_raddr = AW'(cur_ff - 1'b1);
                  state_in  = BK_SHIFT_WR;
               end else begin
                  state_in = BK_PLACE;
               end
            end else if ((cur_ff + 1'b1) < used_ff) begin
               mem_raddr = AW'(cur_ff + 1'b1);
               state_in  = BK_SHIFT_WR;
            end else begin
               used_in  = used_ff - 1'b1;
               state_in = BK_DONE;
            end
         end
         BK_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff[AW-1:0];
            cur_in    = up ? cur_ff - 1'b1 : cur_ff + 1'b1;
            state_in  = BK_SHIFT_RD;
         end
         BK_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[AW-1:0];
            mem_wdata = new_entry;
            used_in   = used_ff + 1'b1;
            state_in  = BK_DONE;
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_handle_in = hout_ff;
               rsp_size_in   = sout_ff;
               rsp_count_in  = COUNT_W'(used_ff);
               state_in      = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      hout_ff       <= hout_in;
      sout_ff       <= sout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule

// File: src/sorted_key_table_search_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert_delete
// Sorted key table with lookup, set (update or insert) and delete.
//
// Requests arrive on req_chan (opcode, key, value_handle, value_size) and
// each produces exactly one response on rsp_chan (status, handle_out,
// size_out, entry_count). A request is transferred when valid and ready are
// both high. A two-entry queue sits behind the request port, so up to two
// requests are taken while the engine works or a response waits.
// The engine does a binary search over one entry memory port, with at most
// log2(CAPACITY)+1 probes; each probe reads an entry and compares its key.
// Update rewrites the found entry in place; delete moves each later entry
// down one place, and insert moves each later entry up one place and then
// writes the new entry at its sorted position.
// The response is held in an output register; if the receiver stalls, the
// engine waits with its next result until the register frees.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_key_table_search_insert_delete #(
   parameter int CAPACITY = skt_pkg::SKT_CAPACITY
) (
   input logic       clock,
   input logic       reset,
   skt_req_if.sink   req_chan,
   skt_rsp_if.source rsp_chan
);
   import skt_pkg::*;

   logic     item_valid;
   logic     item_ready;
   item_type item;

   skt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   skt_back #(.CAPACITY(CAPACITY)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: src/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks on the response channel of the sorted key table.
// ----------------------------------------------------------------------------
module skt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_status,
   input logic [skt_pkg::HANDLE_W-1:0]  rsp_handle_out,
   input logic [skt_pkg::SIZE_W-1:0]    rsp_size_out,
   input logic [skt_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import skt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_handle_out == '0 && rsp_size_out == '0)
      else $error("payload not zero on miss");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED |-> rsp_entry_count != '0)
      else $error("insert left table empty");

endmodule

bind sorted_key_table_search_insert_delete skt_checker u_skt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_handle_out  (rsp_chan.handle_out),
   .rsp_size_out    (rsp_chan.size_out),
   .rsp_entry_count (rsp_chan.entry_count)
);
